// ===== rtl/bbfa_pkg.sv =====
package bbfa_pkg;

  localparam int unsigned HEAP_PAGES_DEF = 16;
  localparam int unsigned BIN_NUMBER_DEF = 10;
  localparam int unsigned PAGE_BYTES     = 4096;
  localparam int unsigned PAGE_WORDS     = PAGE_BYTES / 8;
  localparam int unsigned HDR_BYTES      = 16;

  localparam int unsigned OP_W     = 1;
  localparam int unsigned REQ_W    = 12;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned RSIZE_W  = 13;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_EXHAUSTED = 1'b1;

  // bin i covers sizes up to 8<<i, the last bin takes the rest
  function automatic logic [4:0] bin_of(logic [RSIZE_W-1:0] size, int unsigned nbins);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 15; i++) begin
      if ((i + 1) < nbins && 32'(size) > (32'd8 << i)) begin
        idx = idx + 5'd1;
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/bbfa_if.sv =====
interface bbfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [bbfa_pkg::OP_W-1:0]     op;
  logic [bbfa_pkg::REQ_W-1:0]    req_size;
  logic [bbfa_pkg::ADDR_W-1:0]   block_address;

  modport source (output valid, op, req_size, block_address, input ready);
  modport sink   (input valid, op, req_size, block_address, output ready);
endinterface

interface bbfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bbfa_pkg::ADDR_W-1:0]   address;
  logic                          status;

  modport source (output valid, address, status, input ready);
  modport sink   (input valid, address, status, output ready);
endinterface

// ===== rtl/bbfa_mem.sv =====
module bbfa_mem #(
  parameter int unsigned WORDS = 8192,
  parameter int unsigned IW    = 13
) (
  input  logic                          clk_i,
  input  logic [IW-1:0]                 raddr_i,
  output logic [bbfa_pkg::SIZE_W-1:0]   rsize_o,
  output logic [IW:0]                   rlink_o,
  input  logic                          size_we_i,
  input  logic [IW-1:0]                 size_waddr_i,
  input  logic [bbfa_pkg::SIZE_W-1:0]   size_wdata_i,
  input  logic                          link_we_i,
  input  logic [IW-1:0]                 link_waddr_i,
  input  logic [IW:0]                   link_wdata_i
);

  logic [bbfa_pkg::SIZE_W-1:0] size_mem [WORDS];
  logic [IW:0]                 link_mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (size_we_i) begin
      size_mem[size_waddr_i] <= size_wdata_i;
    end
    rsize_o <= size_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    rlink_o <= link_mem[raddr_i];
  end

endmodule

// ===== rtl/binned_best_fit_allocator_unit.sv =====
// segregated free-list best-fit heap allocator
// req_i carries one transaction per request: op allocate (req_size) or free
// (block_address). rsp_o returns one transaction per request: the granted
// payload address and a status, status set when the heap pages ran out.
// requests are served one at a time. a free first folds the header index
// back into the heap, one heap-sized wrap at a time, then reads the block size
// and pushes the block onto its bin. an allocation walks the free lists in the
// size/link memories entry by entry and bin by bin, runs the whole search
// again after each fresh page, then unlinks, splits and hands over the block.
// the list walk is bound by the single read port of the block memories
// (registered read). the result sits in an output register, so a new request is
// taken while a result still waits; a stalled receiver holds the sequencer
// only when the next result is ready. reset empties all bins and returns all
// pages; block memories are not cleared, they are written before they are read.
module binned_best_fit_allocator_unit #(
  parameter int unsigned HEAP_PAGES = bbfa_pkg::HEAP_PAGES_DEF,
  parameter int unsigned BIN_NUMBER = bbfa_pkg::BIN_NUMBER_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbfa_req_if.sink  req_i,
  bbfa_rsp_if.source rsp_o
);

  localparam int unsigned WORDS = HEAP_PAGES * bbfa_pkg::PAGE_WORDS;
  localparam int unsigned IW    = $clog2(WORDS);
  localparam int unsigned SW    = $clog2(WORDS + 1);
  localparam int unsigned BW    = $clog2(BIN_NUMBER + 1);
  localparam int unsigned BIW   = $clog2(BIN_NUMBER);
  localparam int unsigned PGW   = $clog2(HEAP_PAGES + 1);
  localparam int unsigned TW    = ((IW > 13) ? IW : 13) + 1;
  localparam int unsigned HW    = TW - 9;
  localparam int unsigned RW    = bbfa_pkg::RSIZE_W;
  localparam logic [RW-1:0] PAGE_SIZE = RW'(bbfa_pkg::PAGE_BYTES - bbfa_pkg::HDR_BYTES);
  localparam logic [RW-1:0] HDR       = RW'(bbfa_pkg::HDR_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_FMOD, S_FRD, S_FPUSH, S_ASTART, S_ABIN, S_AWALK, S_ACHK,
    S_ADEC, S_AUNL, S_ACLR, S_ASPLIT, S_DONE
  } state_e;

  state_e          state_q;
  logic [IW:0]     heads_q [BIN_NUMBER];
  logic [PGW-1:0]  pages_q;
  logic [RW-1:0]   rq_q;
  logic [HW-1:0]   hi_q;
  logic [8:0]      lo_q;
  logic [IW-1:0]   w_q;
  logic [BW-1:0]   bin_q;
  logic [IW:0]     cur_q;
  logic [IW-1:0]   prev_q;
  logic            has_prev_q;
  logic [SW-1:0]   steps_q;
  logic            found_q;
  logic [RW-1:0]   mindiff_q;
  logic [IW-1:0]   best_q;
  logic [IW-1:0]   pick_prev_q;
  logic            best_has_prev_q;
  logic [BW-1:0]   best_bin_q;
  logic [IW:0]     best_link_q;
  logic [bbfa_pkg::ADDR_W-1:0] res_addr_q;
  logic            res_status_q;
  logic            out_valid_q;
  logic [bbfa_pkg::ADDR_W-1:0] out_addr_q;
  logic            out_status_q;

  logic [IW-1:0]   mem_raddr;
  logic [bbfa_pkg::SIZE_W-1:0] mem_rsize;
  logic [IW:0]     mem_rlink;
  logic            size_we;
  logic [IW-1:0]   size_waddr;
  logic [bbfa_pkg::SIZE_W-1:0] size_wdata;
  logic            link_we;
  logic [IW-1:0]   link_waddr;
  logic [IW:0]     link_wdata;

  logic [TW-1:0]   free_t;
  logic [RW-1:0]   req_round;
  logic [IW-1:0]   page_w;
  logic [IW+1:0]   nw_sum;
  logic [IW-1:0]   nw;
  logic [RW-1:0]   rem_blk;
  logic [BIW-1:0]  free_bin;
  logic [BIW-1:0]  split_bin;
  logic [BIW-1:0]  page_bin;
  logic [RW-1:0]   chk_diff;
  logic            chk_fit;
  logic            chk_better;
  logic [IW+3:0]   grant;
  logic            rsp_free;

  bbfa_mem #(.WORDS(WORDS), .IW(IW)) u_mem (
    .clk_i        (clk_i),
    .raddr_i      (mem_raddr),
    .rsize_o      (mem_rsize),
    .rlink_o      (mem_rlink),
    .size_we_i    (size_we),
    .size_waddr_i (size_waddr),
    .size_wdata_i (size_wdata),
    .link_we_i    (link_we),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata)
  );

  always_comb begin
    free_t    = TW'(req_i.block_address[15:3]) + TW'(WORDS - 2);
    req_round = (RW'(req_i.req_size) + RW'(7)) & ~RW'(7);
    if (req_i.req_size == '0) begin
      req_round = RW'(8);
    end
    page_w    = IW'({pages_q, 9'b0});
    nw_sum    = (IW+2)'(best_q) + (IW+2)'(2) + (IW+2)'(rq_q[RW-1:3]);
    nw        = (nw_sum >= (IW+2)'(WORDS)) ? IW'(nw_sum - (IW+2)'(WORDS)) : IW'(nw_sum);
    rem_blk   = mindiff_q - HDR;
    free_bin  = BIW'(bbfa_pkg::bin_of(RW'(mem_rsize), BIN_NUMBER));
    split_bin = BIW'(bbfa_pkg::bin_of(rem_blk, BIN_NUMBER));
    page_bin  = BIW'(bbfa_pkg::bin_of(PAGE_SIZE, BIN_NUMBER));
    chk_diff  = RW'(mem_rsize) - rq_q;
    chk_fit   = RW'(mem_rsize) >= rq_q;
    chk_better = chk_fit && (!found_q || chk_diff < mindiff_q);
    grant     = {(IW+1)'(best_q) + (IW+1)'(2), 3'b0};
    rsp_free  = !out_valid_q || rsp_o.ready;
  end

  // memory command per sequencer step
  always_comb begin
    mem_raddr  = (state_q == S_FRD) ? w_q : cur_q[IW-1:0];
    size_we    = 1'b0;
    size_waddr = best_q;
    size_wdata = rq_q[bbfa_pkg::SIZE_W-1:0];
    link_we    = 1'b0;
    link_waddr = best_q;
    link_wdata = '0;
    unique case (state_q)
      S_FPUSH: begin
        link_we    = 1'b1;
        link_waddr = w_q;
        link_wdata = heads_q[free_bin];
      end
      S_ADEC: begin
        if (!found_q && pages_q < PGW'(HEAP_PAGES)) begin
          size_we    = 1'b1;
          size_waddr = page_w;
          size_wdata = PAGE_SIZE[bbfa_pkg::SIZE_W-1:0];
          link_we    = 1'b1;
          link_waddr = page_w;
          link_wdata = heads_q[page_bin];
        end
      end
      S_AUNL: begin
        if (best_has_prev_q) begin
          link_we    = 1'b1;
          link_waddr = pick_prev_q;
          link_wdata = best_link_q;
        end
      end
      S_ACLR: begin
        link_we = 1'b1;
        size_we = (mindiff_q > HDR);
      end
      S_ASPLIT: begin
        size_we    = 1'b1;
        size_waddr = nw;
        size_wdata = rem_blk[bbfa_pkg::SIZE_W-1:0];
        link_we    = 1'b1;
        link_waddr = nw;
        link_wdata = heads_q[split_bin];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < BIN_NUMBER; i++) begin
        heads_q[i] <= '0;
      end
      pages_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      // the handover step reloads the output register itself
      if (out_valid_q && rsp_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            rq_q <= req_round;
            hi_q <= free_t[TW-1:9];
            lo_q <= free_t[8:0];
            state_q <= (req_i.op == bbfa_pkg::OP_FREE) ? S_FMOD : S_ASTART;
          end
        end
        S_FMOD: begin
          // fold the page part of the header index back into the heap
          if (hi_q >= HW'(HEAP_PAGES)) begin
            hi_q <= hi_q - HW'(HEAP_PAGES);
          end else begin
            w_q     <= IW'({hi_q, lo_q});
            state_q <= S_FRD;
          end
        end
        S_FRD: state_q <= S_FPUSH;
        S_FPUSH: begin
          heads_q[free_bin] <= {1'b1, w_q};
          res_addr_q   <= '0;
          res_status_q <= bbfa_pkg::ST_OK;
          state_q      <= S_DONE;
        end
        S_ASTART: begin
          bin_q   <= BW'(bbfa_pkg::bin_of(rq_q, BIN_NUMBER));
          found_q <= 1'b0;
          state_q <= S_ABIN;
        end
        S_ABIN: begin
          if (found_q || bin_q == BW'(BIN_NUMBER)) begin
            state_q <= S_ADEC;
          end else begin
            cur_q      <= heads_q[bin_q[BIW-1:0]];
            has_prev_q <= 1'b0;
            steps_q    <= '0;
            state_q    <= S_AWALK;
          end
        end
        S_AWALK: begin
          // a cyclic list ends after WORDS links
          if (cur_q[IW] && steps_q < SW'(WORDS)) begin
            state_q <= S_ACHK;
          end else begin
            bin_q   <= bin_q + BW'(1);
            state_q <= S_ABIN;
          end
        end
        S_ACHK: begin
          steps_q <= steps_q + SW'(1);
          if (chk_better) begin
            found_q         <= 1'b1;
            mindiff_q       <= chk_diff;
            best_q          <= cur_q[IW-1:0];
            pick_prev_q     <= prev_q;
            best_has_prev_q <= has_prev_q;
            best_bin_q      <= bin_q;
            best_link_q     <= mem_rlink;
          end
          if (chk_better && chk_diff == '0) begin
            state_q <= S_ADEC;
          end else begin
            prev_q     <= cur_q[IW-1:0];
            has_prev_q <= 1'b1;
            cur_q      <= mem_rlink;
            state_q    <= S_AWALK;
          end
        end
        S_ADEC: begin
          if (found_q) begin
            state_q <= S_AUNL;
          end else if (pages_q >= PGW'(HEAP_PAGES)) begin
            res_addr_q   <= '0;
            res_status_q <= bbfa_pkg::ST_EXHAUSTED;
            state_q      <= S_DONE;
          end else begin
            heads_q[page_bin] <= {1'b1, page_w};
            pages_q <= pages_q + PGW'(1);
            state_q <= S_ASTART;
          end
        end
        S_AUNL: begin
          if (!best_has_prev_q) begin
            heads_q[best_bin_q[BIW-1:0]] <= best_link_q;
          end
          state_q <= S_ACLR;
        end
        S_ACLR: begin
          res_addr_q   <= bbfa_pkg::ADDR_W'(grant);
          res_status_q <= bbfa_pkg::ST_OK;
          state_q      <= (mindiff_q > HDR) ? S_ASPLIT : S_DONE;
        end
        S_ASPLIT: begin
          heads_q[split_bin] <= {1'b1, nw};
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            out_valid_q  <= 1'b1;
            out_addr_q   <= res_addr_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.address = out_addr_q;
  assign rsp_o.status  = out_status_q;

  a_pages_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pages_q <= PGW'(HEAP_PAGES))
    else $error("page count beyond heap");

  a_exhausted_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_status_q == bbfa_pkg::ST_EXHAUSTED) |->
      pages_q == PGW'(HEAP_PAGES))
    else $error("exhausted status with pages left");

  a_error_no_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == bbfa_pkg::ST_EXHAUSTED) |-> out_addr_q == '0)
    else $error("address granted on exhausted heap");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACHK) |-> steps_q < SW'(WORDS))
    else $error("list walk past step limit");

endmodule
